// ===== rtl/core/mfes_pkg.sv =====
package mfes_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int LEN_W       = 4;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int PAT_W       = 8 * MAX_PATTERN;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [1:0] CFG_FLAG_LEN   = 2'd0;
    localparam logic [1:0] CFG_FLAG_BYTES = 2'd1;
    localparam logic [1:0] CFG_ESC_LEN    = 2'd2;
    localparam logic [1:0] CFG_ESC_BYTES  = 2'd3;

    localparam logic [LEN_W-1:0] RST_FLAG_LEN   = 4'd4;
    localparam logic [PAT_W-1:0] RST_FLAG_BYTES = 64'h0000_0000_464C_4147;
    localparam logic [LEN_W-1:0] RST_ESC_LEN    = 4'd6;
    localparam logic [PAT_W-1:0] RST_ESC_BYTES  = 64'h0000_4553_4341_5045;

    // command carried with each input item
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_EOF  = 1'b1;

    typedef struct packed {
        logic       open;   // first item of a frame: start flag goes first
        logic       cmd;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [LEN_W-1:0] flag_len;
        logic [PAT_W-1:0] flag_bytes;
        logic [LEN_W-1:0] esc_len;
        logic [PAT_W-1:0] esc_bytes;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_RESOLVE,
        ST_ESC,
        ST_PAT2,
        ST_END,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        MATCH_NO,
        MATCH_YES,
        MATCH_WAIT
    } t_match;

    typedef enum logic [2:0] {
        DEC_EMPTY,
        DEC_WAIT,
        DEC_ESC,
        DEC_FLAG,
        DEC_PASS
    } t_dec;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        r = len;
        if (len == '0) begin
            r = LEN_W'(1);
        end else if (len > LEN_W'(MAX_PATTERN)) begin
            r = LEN_W'(MAX_PATTERN);
        end
        return r;
    endfunction

    function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] bytes,
                                            input logic [IDX_W-1:0] i);
        return bytes[{i, 3'b000} +: 8];
    endfunction

endpackage

// ===== rtl/core/mfes_front.sv =====
module mfes_front import mfes_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  logic  i_cmd,
    input  logic  [7:0] i_data,
    input  logic  i_q_full,
    output logic  o_push,
    output t_item o_item
);

    logic r_in_frame;
    logic n_in_frame;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // tag the first item of each frame
    assign o_item.open = !r_in_frame;
    assign o_item.cmd  = i_cmd;
    assign o_item.data = i_data;

    always_comb begin
        n_in_frame = r_in_frame;
        if (o_push) begin
            n_in_frame = (i_cmd == CMD_BYTE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
        end
    end

endmodule

// ===== rtl/core/mfes_queue.sv =====
module mfes_queue import mfes_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/mfes_back.sv =====
module mfes_back import mfes_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_q_empty,
    input  t_item i_q_item,
    output logic  o_q_pop,
    output logic  o_valid,
    input  logic  i_ready,
    output logic  [7:0] o_byte,
    output logic  o_done,
    output logic  o_last
);

    t_state             r_state;
    t_state             n_state;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic               r_pat2_flag;
    logic               n_pat2_flag;
    logic               r_cmd;
    logic [PAT_W-1:0]   r_win;
    logic [PAT_W-1:0]   n_win;
    logic [LEN_W-1:0]   r_fill;
    logic [LEN_W-1:0]   n_fill;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_pend_valid;
    logic [7:0]         r_pend_byte;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_done;
    logic               r_out_last;

    logic [LEN_W-1:0]   flen;
    logic [LEN_W-1:0]   elen;
    logic [LEN_W-1:0]   len2;
    logic               e_mis;
    logic               f_mis;
    t_match             e_res;
    t_match             f_res;
    t_dec               dec;
    logic               emit;
    logic [7:0]         e_byte;
    logic               fin;
    logic               drop;
    logic [LEN_W-1:0]   drop_n;
    logic               keep;
    logic               release_pend;
    logic               out_free;
    logic               stall;
    logic               pop;
    logic               flag_last;
    logic               esc_last;
    logic               pat2_last;

    assign flen = clamp_len(i_cfg.flag_len);
    assign elen = clamp_len(i_cfg.esc_len);
    assign len2 = r_pat2_flag ? flen : elen;

    assign flag_last = (LEN_W'(r_idx) == flen - LEN_W'(1));
    assign esc_last  = (LEN_W'(r_idx) == elen - LEN_W'(1));
    assign pat2_last = (LEN_W'(r_idx) == len2 - LEN_W'(1));

    // compare the window head against both patterns, byte lanes in parallel
    always_comb begin
        e_mis = 1'b0;
        f_mis = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (LEN_W'(i) < r_fill && LEN_W'(i) < elen
                    && r_win[8*i +: 8] != pat_byte(i_cfg.esc_bytes, IDX_W'(i))) begin
                e_mis = 1'b1;
            end
            if (LEN_W'(i) < r_fill && LEN_W'(i) < flen
                    && r_win[8*i +: 8] != pat_byte(i_cfg.flag_bytes, IDX_W'(i))) begin
                f_mis = 1'b1;
            end
        end
    end

    // at end of frame bytes still to come count as mismatches
    always_comb begin
        if (e_mis) begin
            e_res = MATCH_NO;
        end else if (r_fill >= elen) begin
            e_res = MATCH_YES;
        end else if (r_cmd == CMD_EOF) begin
            e_res = MATCH_NO;
        end else begin
            e_res = MATCH_WAIT;
        end
        if (f_mis) begin
            f_res = MATCH_NO;
        end else if (r_fill >= flen) begin
            f_res = MATCH_YES;
        end else if (r_cmd == CMD_EOF) begin
            f_res = MATCH_NO;
        end else begin
            f_res = MATCH_WAIT;
        end
    end

    // escape wins over flag at the same position
    always_comb begin
        if (r_fill == '0) begin
            dec = DEC_EMPTY;
        end else if (e_res == MATCH_WAIT) begin
            dec = DEC_WAIT;
        end else if (e_res == MATCH_YES) begin
            dec = DEC_ESC;
        end else if (f_res == MATCH_WAIT) begin
            dec = DEC_WAIT;
        end else if (f_res == MATCH_YES) begin
            dec = DEC_FLAG;
        end else begin
            dec = DEC_PASS;
        end
    end

    // sequencer outputs
    always_comb begin
        emit   = 1'b0;
        e_byte = '0;
        fin    = 1'b0;
        drop   = 1'b0;
        drop_n = LEN_W'(1);
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_START, ST_END: begin
                emit   = 1'b1;
                e_byte = pat_byte(i_cfg.flag_bytes, r_idx);
            end
            ST_RESOLVE: begin
                unique case (dec)
                    DEC_EMPTY: begin
                        fin = (r_cmd == CMD_BYTE);
                    end
                    DEC_WAIT: begin
                        fin = 1'b1;
                    end
                    DEC_ESC: begin
                        emit   = 1'b1;
                        e_byte = pat_byte(i_cfg.esc_bytes, '0);
                        drop   = 1'b1;
                        drop_n = elen;
                    end
                    DEC_FLAG: begin
                        emit   = 1'b1;
                        e_byte = pat_byte(i_cfg.esc_bytes, '0);
                        drop   = 1'b1;
                        drop_n = flen;
                    end
                    DEC_PASS: begin
                        emit   = 1'b1;
                        e_byte = r_win[7:0];
                        drop   = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_ESC: begin
                emit   = 1'b1;
                e_byte = pat_byte(i_cfg.esc_bytes, r_idx);
            end
            ST_PAT2: begin
                emit   = 1'b1;
                e_byte = r_pat2_flag ? pat_byte(i_cfg.flag_bytes, r_idx)
                                     : pat_byte(i_cfg.esc_bytes, r_idx);
            end
            ST_FIN: begin
                fin = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // results past the cap are dropped; the held byte then stays the last one
    assign keep         = emit && (r_cnt < CNT_W'(MAX_RESULTS));
    assign release_pend = r_pend_valid && (fin || keep);
    assign out_free     = !r_out_valid || i_ready;
    assign stall        = release_pend && !out_free;
    assign pop          = !i_q_empty && ((r_state == ST_IDLE) || (fin && !stall));
    assign o_q_pop      = pop;

    // next state
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pat2_flag = r_pat2_flag;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_START: begin
                if (flag_last) begin
                    n_state = ST_RESOLVE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_RESOLVE: begin
                unique case (dec)
                    DEC_EMPTY: begin
                        if (r_cmd == CMD_EOF) begin
                            n_state = ST_END;
                            n_idx   = '0;
                        end
                    end
                    DEC_ESC, DEC_FLAG: begin
                        n_pat2_flag = (dec == DEC_FLAG);
                        if (elen == LEN_W'(1)) begin
                            n_state = ST_PAT2;
                            n_idx   = '0;
                        end else begin
                            n_state = ST_ESC;
                            n_idx   = IDX_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_ESC: begin
                if (esc_last) begin
                    n_state = ST_PAT2;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_PAT2: begin
                if (pat2_last) begin
                    n_state = ST_RESOLVE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_END: begin
                if (flag_last) begin
                    n_state = ST_FIN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_FIN: begin
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (fin) begin
            n_state = ST_IDLE;
            n_idx   = '0;
        end
        if (pop) begin
            n_state = i_q_item.open ? ST_START : ST_RESOLVE;
            n_idx   = '0;
        end
    end

    // window: drop a resolved head, append a new byte at the tail
    always_comb begin
        n_win  = r_win;
        n_fill = r_fill;
        if (drop) begin
            n_win  = r_win >> {drop_n, 3'b000};
            n_fill = r_fill - drop_n;
        end
        if (pop && i_q_item.cmd == CMD_BYTE && !r_fill[LEN_W-1]) begin
            n_win[{r_fill[IDX_W-1:0], 3'b000} +: 8] = i_q_item.data;
            n_fill = r_fill + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_fill       <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (!stall) begin
                r_state <= n_state;
                r_idx   <= n_idx;
                r_fill  <= n_fill;
                if (fin) begin
                    r_cnt <= '0;
                end else if (keep) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                if (keep) begin
                    r_pend_valid <= 1'b1;
                end else if (fin) begin
                    r_pend_valid <= 1'b0;
                end
            end
            if (release_pend && !stall) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_win       <= n_win;
            r_pat2_flag <= n_pat2_flag;
            if (pop) begin
                r_cmd <= i_q_item.cmd;
            end
            if (keep) begin
                r_pend_byte <= e_byte;
            end
        end
        if (release_pend && !stall) begin
            r_out_byte <= r_pend_byte;
            r_out_last <= fin;
            r_out_done <= fin && (r_cmd == CMD_EOF);
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_done  = r_out_done;
    assign o_last  = r_out_last;

endmodule

// ===== rtl/core/multibyte_flag_escape_stuffer_unit.sv =====
// A pass-through byte of an open frame is queued, enters the window, is held back as pending
//   result and is then registered at the output. One stuffed byte per cycle (dropped ones
//   too) unless the output stalls; the back end pops a new item only when idle or as it closes the last one.
// A 4-entry input queue lets the front keep taking items while an expansion is emitted.
// Reset (synchronous, active low): no frame open, empty window and queue, output idle,
//   registers back to a 4-byte "GALF" flag and a 6-byte "EPACSE" escape.
module multibyte_flag_escape_stuffer_unit import mfes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
    input  logic        s_axis_tuser,   // [0] command
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tuser,   // [0] frame_done
    output logic        m_axis_tlast,   // run_last
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata
);

    t_cfg  r_cfg;
    t_item front_item;
    t_item q_item;
    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;

    // Configuration registers: lengths keep their low nibble, clamping happens at use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_len   <= RST_FLAG_LEN;
            r_cfg.flag_bytes <= RST_FLAG_BYTES;
            r_cfg.esc_len    <= RST_ESC_LEN;
            r_cfg.esc_bytes  <= RST_ESC_BYTES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FLAG_LEN:   r_cfg.flag_len   <= i_cfg_wdata[LEN_W-1:0];
                CFG_FLAG_BYTES: r_cfg.flag_bytes <= i_cfg_wdata;
                CFG_ESC_LEN:    r_cfg.esc_len    <= i_cfg_wdata[LEN_W-1:0];
                CFG_ESC_BYTES:  r_cfg.esc_bytes  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Front: take transfers in and mark the opening item of each frame.
    mfes_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_cmd    (s_axis_tuser),
        .i_data   (s_axis_tdata),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_item   (front_item)
    );

    // Queue: decouple the front from the bursty back end.
    mfes_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: hold the lookahead window, resolve matches, emit flags and escapes.
    // One result byte is held back so the last byte of each item can be marked.
    mfes_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_done    (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

endmodule
